/* sv/deq_pkg.sv */
// Shared types and constants for the double-ended queue unit.
// Holds operation and status codes, stream widths and the
// command and status structs between controller and datapath. No dependencies.
package deq_pkg;

    // Default ring depth.
    localparam int DEPTH_DEFAULT = 16;

    // Field widths.
    localparam int OP_W     = 3;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 5;

    // Stream data widths, padded to whole bytes.
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;

    // Operation codes.
    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_REMOVE     = 3'd4
    } op_t;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Datapath commands issued by the controller.
    typedef enum logic [3:0] {
        CMD_NONE       = 4'd0,
        CMD_CAPTURE    = 4'd1,
        CMD_PUSH_FRONT = 4'd2,
        CMD_PUSH_BACK  = 4'd3,
        CMD_READ_FRONT = 4'd4,
        CMD_READ_BACK  = 4'd5,
        CMD_POP_FRONT  = 4'd6,
        CMD_POP_BACK   = 4'd7,
        CMD_SCAN_START = 4'd8,
        CMD_SCAN_STEP  = 4'd9,
        CMD_SCAN_END   = 4'd10,
        CMD_RESULT     = 4'd11
    } cmd_code_t;

    // Command bundle from controller to datapath.
    typedef struct packed {
        cmd_code_t code;
        logic      set_status;
        status_t   status;
    } dp_cmd_t;

    // Status bundle from datapath to controller.
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            empty;
        logic            full;
        logic            scan_done;
        logic            out_free;
    } dp_sts_t;

endpackage

/* sv/double_ended_queue_unit.sv */
// Double-ended queue unit: push/pop at either end and remove-all-equal.
// Each item is captured and executed; pops then wait for their RAM read and removal runs
// a compaction scan with one RAM read per entry, before the result is loaded. One item
// is in flight at a time; a result held by m_tready low keeps the next result from loading.
// Synchronous active-low reset empties the queue; entries themselves are not cleared.
module double_ended_queue_unit
    import deq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // [2:0] operation, [34:3] value, [39:35] zero
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata   // [1:0] status, [33:2] popped_value,
                                           // [38:34] occupancy, [39] zero
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    // Sequencing of each item.
    deq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Storage, pointers and the result register.
    deq_datapath #(
        .DEPTH(DEPTH)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .cmd     (cmd),
        .sts     (sts)
    );

endmodule

/* sv/deq_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// Parameters set word width and depth. No dependencies.
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* sv/deq_datapath.sv */
// Datapath of the double-ended queue: ring pointers, entry count, the entry
// RAM, the compaction scan counters and the result output register.
// Depends on deq_pkg and deq_ram.
module deq_datapath
    import deq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    input  dp_cmd_t              cmd,
    output dp_sts_t              sts
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [IDX_W:0]   RING_LEN = (IDX_W + 1)'(DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    // Offset a ring position, wrapping at the ring length.
    function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
                                                  input logic [IDX_W-1:0] off);
        logic [IDX_W:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= RING_LEN) begin
            sum = sum - RING_LEN;
        end
        return sum[IDX_W-1:0];
    endfunction

    // State and payload registers.
    logic [OP_W-1:0]   op_reg, op_next;
    logic [DATA_W-1:0] value_reg, value_next;
    logic [DATA_W-1:0] popped_reg, popped_next;
    status_t           status_reg, status_next;
    logic [IDX_W-1:0]  front_reg, front_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0]  kept_reg, kept_next;
    logic              pend_reg, pend_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    // RAM interface.
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic [IDX_W-1:0]  rd_addr;
    logic [DATA_W-1:0] rd_data;

    logic [CNT_W-1:0]       back_off;
    logic [IDX_W-1:0]       front_dec;
    logic [OCC_W+CNT_W-1:0] occ_wide;

    deq_ram #(
        .WIDTH(DATA_W),
        .DEPTH(DEPTH)
    ) u_ram (
        .aclk   (aclk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    assign back_off  = count_reg - CNT_W'(1);
    assign front_dec = (front_reg == '0) ? LAST_IDX : front_reg - IDX_W'(1);
    assign occ_wide  = {{OCC_W{1'b0}}, count_reg};

    // Command decode and next-state logic.
    always_comb begin
        op_next       = op_reg;
        value_next    = value_reg;
        popped_next   = popped_reg;
        status_next   = status_reg;
        front_next    = front_reg;
        count_next    = count_reg;
        rd_idx_next   = rd_idx_reg;
        kept_next     = kept_reg;
        pend_next     = pend_reg;
        m_tdata_next  = m_tdata_reg;
        m_tvalid_next = m_tvalid_reg & ~m_tready;
        wr_en         = 1'b0;
        wr_addr       = front_reg;
        wr_data       = value_reg;
        rd_addr       = front_reg;

        if (cmd.set_status) begin
            status_next = cmd.status;
        end

        case (cmd.code)
            CMD_CAPTURE: begin
                op_next     = s_tdata[OP_W-1:0];
                value_next  = s_tdata[OP_W+DATA_W-1:OP_W];
                popped_next = '0;
            end
            CMD_PUSH_FRONT: begin
                wr_en      = 1'b1;
                wr_addr    = front_dec;
                front_next = front_dec;
                count_next = count_reg + CNT_W'(1);
            end
            CMD_PUSH_BACK: begin
                wr_en      = 1'b1;
                wr_addr    = ring_add(front_reg, count_reg[IDX_W-1:0]);
                count_next = count_reg + CNT_W'(1);
            end
            CMD_READ_FRONT: begin
                rd_addr = front_reg;
            end
            CMD_READ_BACK: begin
                rd_addr = ring_add(front_reg, back_off[IDX_W-1:0]);
            end
            CMD_POP_FRONT: begin
                popped_next = rd_data;
                front_next  = ring_add(front_reg, IDX_W'(1));
                count_next  = back_off;
            end
            CMD_POP_BACK: begin
                popped_next = rd_data;
                count_next  = back_off;
            end
            CMD_SCAN_START: begin
                rd_idx_next = '0;
                kept_next   = '0;
                pend_next   = 1'b0;
            end
            CMD_SCAN_STEP: begin
                // Issue the next read while the previous entry comes back.
                if (rd_idx_reg < count_reg) begin
                    rd_addr     = ring_add(front_reg, rd_idx_reg[IDX_W-1:0]);
                    rd_idx_next = rd_idx_reg + CNT_W'(1);
                    pend_next   = 1'b1;
                end else begin
                    pend_next = 1'b0;
                end
                // Survivors are moved down to the next kept slot.
                if (pend_reg && (rd_data != value_reg)) begin
                    wr_en     = 1'b1;
                    wr_addr   = ring_add(front_reg, kept_reg[IDX_W-1:0]);
                    wr_data   = rd_data;
                    kept_next = kept_reg + CNT_W'(1);
                end
            end
            CMD_SCAN_END: begin
                count_next = kept_reg;
            end
            CMD_RESULT: begin
                m_tdata_next  = {{(M_TDATA_W - STATUS_W - DATA_W - OCC_W){1'b0}},
                                 occ_wide[OCC_W-1:0], popped_reg, status_reg};
                m_tvalid_next = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_reg    <= '0;
            count_reg    <= '0;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            front_reg    <= front_next;
            count_reg    <= count_next;
            pend_reg     <= pend_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        op_reg      <= op_next;
        value_reg   <= value_next;
        popped_reg  <= popped_next;
        status_reg  <= status_next;
        rd_idx_reg  <= rd_idx_next;
        kept_reg    <= kept_next;
        m_tdata_reg <= m_tdata_next;
    end

    // Status toward the controller.
    assign sts.op        = op_reg;
    assign sts.empty     = (count_reg == '0);
    assign sts.full      = (count_reg == FULL_CNT);
    assign sts.scan_done = (rd_idx_reg == count_reg) && !pend_reg;
    assign sts.out_free  = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

/* sv/deq_ctrl.sv */
// Controller state machine of the double-ended queue. Sequences one item
// through execute, pop read wait or compaction scan, and result load.
// Depends on deq_pkg.
module deq_ctrl
    import deq_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_tvalid,
    output logic    s_tready,
    input  dp_sts_t sts,
    output dp_cmd_t cmd
);

    typedef enum logic [4:0] {
        S_IDLE     = 5'b00001,
        S_EXEC     = 5'b00010,
        S_POP_WAIT = 5'b00100,
        S_SCAN     = 5'b01000,
        S_RESULT   = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // Next state and command decode.
    always_comb begin
        state_next     = state_reg;
        cmd.code       = CMD_NONE;
        cmd.set_status = 1'b0;
        cmd.status     = ST_OK;
        s_tready       = 1'b0;

        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.code   = CMD_CAPTURE;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                cmd.set_status = 1'b1;
                state_next     = S_RESULT;
                case (sts.op) inside
                    OP_PUSH_FRONT, OP_PUSH_BACK: begin
                        if (sts.full) begin
                            cmd.status = ST_FULL;
                        end else if (sts.op == OP_PUSH_FRONT) begin
                            cmd.code = CMD_PUSH_FRONT;
                        end else begin
                            cmd.code = CMD_PUSH_BACK;
                        end
                    end
                    OP_POP_FRONT, OP_POP_BACK: begin
                        if (sts.empty) begin
                            cmd.status = ST_EMPTY;
                        end else begin
                            cmd.code   = (sts.op == OP_POP_FRONT) ? CMD_READ_FRONT
                                                                  : CMD_READ_BACK;
                            state_next = S_POP_WAIT;
                        end
                    end
                    OP_REMOVE: begin
                        if (sts.empty) begin
                            cmd.status = ST_EMPTY;
                        end else begin
                            cmd.code   = CMD_SCAN_START;
                            state_next = S_SCAN;
                        end
                    end
                    default: begin
                        // Unused operation codes leave the queue untouched.
                        cmd.status = ST_OK;
                    end
                endcase
            end
            S_POP_WAIT: begin
                cmd.code   = (sts.op == OP_POP_FRONT) ? CMD_POP_FRONT : CMD_POP_BACK;
                state_next = S_RESULT;
            end
            S_SCAN: begin
                if (sts.scan_done) begin
                    cmd.code   = CMD_SCAN_END;
                    state_next = S_RESULT;
                end else begin
                    cmd.code = CMD_SCAN_STEP;
                end
            end
            S_RESULT: begin
                if (sts.out_free) begin
                    cmd.code   = CMD_RESULT;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
